FILE: src/vmpc_pkg.sv
// Shared constants and command/status types for the VMPC cipher engine.
// No dependencies; imported by vmpc_ctrl, vmpc_dpath and vmpc_stream_cipher.
`default_nettype none
package vmpc_pkg;

   localparam int KSA_ROUNDS = 665;
   localparam int KEY_BYTES  = 32;
   localparam int KEY_REGS   = 4;

   // datapath operation codes
   localparam logic [3:0] OP_NOP      = 4'd0;
   localparam logic [3:0] OP_START    = 4'd1;
   localparam logic [3:0] OP_LATCH    = 4'd2;
   localparam logic [3:0] OP_K_RD_N   = 4'd3;
   localparam logic [3:0] OP_K_RD_IDX = 4'd4;
   localparam logic [3:0] OP_K_RD_MIX = 4'd5;
   localparam logic [3:0] OP_K_WR_N   = 4'd6;
   localparam logic [3:0] OP_K_WR_MIX = 4'd7;
   localparam logic [3:0] OP_C_RD_BC  = 4'd8;
   localparam logic [3:0] OP_C_RD_IDX = 4'd9;
   localparam logic [3:0] OP_C_RD_MIX = 4'd10;
   localparam logic [3:0] OP_C_RD_A   = 4'd11;
   localparam logic [3:0] OP_C_RD_KS  = 4'd12;
   localparam logic [3:0] OP_C_WR_BC  = 4'd13;
   localparam logic [3:0] OP_C_WR_MIX = 4'd14;

   localparam logic CMD_REKEY = 1'b0;
   localparam logic CMD_CRYPT = 1'b1;

   typedef struct packed {
      logic [3:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic round_last;
   } dp_status_type;

endpackage
`default_nettype wire

FILE: src/vmpc_ctrl.sv
// Sequencer for the VMPC engine: key schedule rounds and crypt steps.
// Depends on vmpc_pkg; drives vmpc_dpath through dp_cmd_type.
`default_nettype none
module vmpc_ctrl
   import vmpc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic          req_cmd,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_K_RD_N    = 4'd1;
   localparam logic [3:0] S_K_RD_IDX  = 4'd2;
   localparam logic [3:0] S_K_RD_MIX  = 4'd3;
   localparam logic [3:0] S_K_WR_N    = 4'd4;
   localparam logic [3:0] S_K_WR_MIX  = 4'd5;
   localparam logic [3:0] S_C_RD_BC   = 4'd6;
   localparam logic [3:0] S_C_RD_IDX  = 4'd7;
   localparam logic [3:0] S_C_RD_MIX  = 4'd8;
   localparam logic [3:0] S_C_RD_A    = 4'd9;
   localparam logic [3:0] S_C_RD_KS   = 4'd10;
   localparam logic [3:0] S_C_WR_BC   = 4'd11;
   localparam logic [3:0] S_C_WR_MIX  = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_REKEY) begin
                  cmd.op   = OP_START;
                  state_in = S_K_RD_N;
               end else begin
                  cmd.op   = OP_LATCH;
                  state_in = S_C_RD_BC;
               end
            end
         end
         S_K_RD_N: begin
            cmd.op   = OP_K_RD_N;
            state_in = S_K_RD_IDX;
         end
         S_K_RD_IDX: begin
            cmd.op   = OP_K_RD_IDX;
            state_in = S_K_RD_MIX;
         end
         S_K_RD_MIX: begin
            cmd.op   = OP_K_RD_MIX;
            state_in = S_K_WR_N;
         end
         S_K_WR_N: begin
            cmd.op   = OP_K_WR_N;
            state_in = S_K_WR_MIX;
         end
         S_K_WR_MIX: begin
            cmd.op   = OP_K_WR_MIX;
            state_in = status.round_last ? S_IDLE : S_K_RD_N;
         end
         S_C_RD_BC: begin
            cmd.op   = OP_C_RD_BC;
            state_in = S_C_RD_IDX;
         end
         S_C_RD_IDX: begin
            cmd.op   = OP_C_RD_IDX;
            state_in = S_C_RD_MIX;
         end
         S_C_RD_MIX: begin
            cmd.op   = OP_C_RD_MIX;
            state_in = S_C_RD_A;
         end
         S_C_RD_A: begin
            cmd.op   = OP_C_RD_A;
            state_in = S_C_RD_KS;
         end
         S_C_RD_KS: begin
            cmd.op   = OP_C_RD_KS;
            state_in = S_C_WR_BC;
         end
         S_C_WR_BC: begin
            cmd.op   = OP_C_WR_BC;
            state_in = S_C_WR_MIX;
         end
         S_C_WR_MIX: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op   = OP_C_WR_MIX;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.op == OP_C_WR_MIX) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/vmpc_dpath.sv
// VMPC datapath: permutation memory with per-entry valid bits, indices, key
// registers and output byte. Depends on vmpc_pkg; driven by vmpc_ctrl.
`default_nettype none
module vmpc_dpath
   import vmpc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_we,
   input  wire logic [1:0]    csr_addr,
   input  wire logic [63:0]   csr_wdata,
   input  wire logic [7:0]    req_data,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      status,
   output logic [7:0]         out_byte
);

   localparam logic [9:0] ROUND_LAST = 10'(KSA_ROUNDS - 1);
   localparam logic [8:0] KEY_LIMIT  = 9'(KEY_BYTES);

   logic [7:0]  perm_mem [0:255];
   logic [255:0] valid_ff;

   logic [63:0] key_ff [0:KEY_REGS-1];
   logic [255:0] key_all;

   logic [7:0] mix_ff, mix_in;
   logic [7:0] bc_ff, bc_in;
   logic [9:0] round_ff, round_in;
   logic [7:0] pn_ff, pn_in;
   logic [7:0] pm_ff, pm_in;
   logic [7:0] ks_ff, ks_in;
   logic [7:0] data_ff, data_in;
   logic [7:0] out_ff, out_in;

   logic [7:0] rd_q, rd_addr_q;
   logic       rd_vld_q;
   logic [7:0] rd;

   logic [7:0] mem_addr, mem_wdata;
   logic       mem_we;
   logic [7:0] key_byte;
   logic [7:0] n_idx;

   assign key_all  = {key_ff[3], key_ff[2], key_ff[1], key_ff[0]};
   assign n_idx    = round_ff[7:0];
   // entries never written since the last rekey hold their own index
   assign rd       = rd_vld_q ? rd_q : rd_addr_q;
   assign key_byte = (n_idx[7:5] == 3'd0 && {1'b0, n_idx} < KEY_LIMIT)
                     ? key_all[{n_idx[4:0], 3'b000} +: 8] : 8'd0;

   assign status.round_last = (round_ff == ROUND_LAST);
   assign out_byte          = out_ff;

   always_comb begin
      mix_in    = mix_ff;
      bc_in     = bc_ff;
      round_in  = round_ff;
      pn_in     = pn_ff;
      pm_in     = pm_ff;
      ks_in     = ks_ff;
      data_in   = data_ff;
      out_in    = out_ff;
      mem_addr  = mix_ff;
      mem_wdata = pn_ff;
      mem_we    = 1'b0;
      case (cmd.op)
         OP_START: begin
            mix_in   = 8'd0;
            round_in = 10'd0;
         end
         OP_LATCH: data_in = req_data;
         OP_K_RD_N: mem_addr = n_idx;
         OP_K_RD_IDX: begin
            pn_in    = rd;
            mem_addr = mix_ff + rd + key_byte;
         end
         OP_K_RD_MIX: begin
            mix_in   = rd;
            mem_addr = rd;
         end
         OP_K_WR_N: begin
            mem_we    = 1'b1;
            mem_addr  = n_idx;
            mem_wdata = rd;
         end
         OP_K_WR_MIX: begin
            mem_we    = 1'b1;
            mem_addr  = mix_ff;
            mem_wdata = pn_ff;
            round_in  = round_ff + 10'd1;
            if (status.round_last) begin
               bc_in = 8'd0;
            end
         end
         OP_C_RD_BC: mem_addr = bc_ff;
         OP_C_RD_IDX: begin
            pn_in    = rd;
            mem_addr = mix_ff + rd;
         end
         OP_C_RD_MIX: begin
            mix_in   = rd;
            mem_addr = rd;
         end
         OP_C_RD_A: begin
            pm_in    = rd;
            mem_addr = rd;
         end
         OP_C_RD_KS: mem_addr = rd + 8'd1;
         OP_C_WR_BC: begin
            ks_in     = rd;
            mem_we    = 1'b1;
            mem_addr  = bc_ff;
            mem_wdata = pm_ff;
         end
         OP_C_WR_MIX: begin
            mem_we    = 1'b1;
            mem_addr  = mix_ff;
            mem_wdata = pn_ff;
            bc_in     = bc_ff + 8'd1;
            out_in    = data_ff ^ ks_ff;
         end
         default: begin
         end
      endcase
   end

   // single-port permutation store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         perm_mem[mem_addr] <= mem_wdata;
      end
      rd_q      <= perm_mem[mem_addr];
      rd_vld_q  <= valid_ff[mem_addr];
      rd_addr_q <= mem_addr;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.op == OP_START) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[mem_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_REGS; k++) begin
            key_ff[k] <= 64'd0;
         end
      end else if (csr_we) begin
         key_ff[csr_addr] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_ff   <= 8'd0;
         bc_ff    <= 8'd0;
         round_ff <= 10'd0;
      end else begin
         mix_ff   <= mix_in;
         bc_ff    <= bc_in;
         round_ff <= round_in;
      end
      pn_ff   <= pn_in;
      pm_ff   <= pm_in;
      ks_ff   <= ks_in;
      data_ff <= data_in;
      out_ff  <= out_in;
   end

endmodule
`default_nettype wire

FILE: src/vmpc_stream_cipher.sv
// VMPC stream cipher engine. Rekey item: busy for KSA_ROUNDS schedule rounds after
// the accept, five single-port accesses of the permutation per round; no result.
// Crypt item: accepted in idle, result registered in the last write step; a new item
// is taken only in idle, after five dependent reads and two writes on the one table
// port. An untaken result stalls the next crypt before its last write.
// Reset (synchronous, active high): identity permutation via cleared valid
// bits, indices and key registers zero, no result pending.
`default_nettype none
module vmpc_stream_cipher
   import vmpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] cmd: 0 rekey, 1 crypt
   // result items
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   // key registers, index 0..3
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [63:0] csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // sequencer: one table access per cycle unless an untaken result stalls it, result held until taken
   vmpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   // permutation store, indices, keys and output byte register
   vmpc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_data  (req_tdata),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .out_byte  (rsp_tdata)
   );

endmodule
`default_nettype wire
